// ===== hdl/wrm_pkg.sv =====
// Shared constants, codes and types of the windowed RMS meter.
`timescale 1ns / 1ps
`default_nettype none

package wrm_pkg;

   // Window limits
   localparam int MAX_SAMPLES = 512;
   localparam int SAMPLE_BITS = 12;

   // Port field widths
   localparam int CODE_W   = 12;
   localparam int OFF_W    = 12;
   localparam int GAIN_W   = 18;
   localparam int CSR_W    = 18;
   localparam int CSR_IDX_W = 2;
   localparam int RMS_W    = 21;
   localparam int USED_W   = 10;
   localparam int STATUS_W = 2;

   // Internal widths; most follow from the window limits and port widths
   localparam int CODE_USE_W = (SAMPLE_BITS < CODE_W) ? SAMPLE_BITS : CODE_W;
   localparam int SQ_W       = 2 * SAMPLE_BITS;
   localparam int COUNT_W    = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W      = SQ_W + COUNT_W;
   localparam int FRAC_W     = 8;
   localparam int DIV_W      = SUM_W + FRAC_W;
   localparam int ROOT_IN_W  = DIV_W + (DIV_W % 2);
   localparam int RT_W       = ROOT_IN_W / 2;
   localparam int OFFQ_W     = OFF_W + 4;
   localparam int MAG_W      = (RT_W > OFFQ_W) ? RT_W : OFFQ_W;
   localparam int PROD_W     = MAG_W + GAIN_W;
   localparam int SCALE_SHIFT = 12;
   localparam int SUMR_W     = PROD_W + 1;
   localparam int SCALED_W   = SUMR_W - SCALE_SHIFT;
   localparam int STEP_W     = $clog2(DIV_W + 1);

   localparam logic [SUMR_W-1:0]   ROUND_HALF  = SUMR_W'(1) << (SCALE_SHIFT - 1);
   localparam logic [SCALED_W-1:0] RMS_POS_MAX = SCALED_W'((1 << (RMS_W - 1)) - 1);
   localparam logic [SCALED_W-1:0] RMS_NEG_MAG = SCALED_W'(1 << (RMS_W - 1));

   // Job queue between the accumulator and the arithmetic back end
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Codes
   localparam logic ACTION_SAMPLE = 1'b0;
   localparam logic ACTION_END    = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DROP  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN   = 2'd1;

   localparam logic [OFF_W-1:0]  OFFSET_RESET = 12'd503;
   localparam logic [GAIN_W-1:0] GAIN_RESET   = 18'd51441;

   typedef struct packed {
      logic [SUM_W-1:0]   sum;
      logic [COUNT_W-1:0] count;
      logic               overflow;
   } job_type;

   typedef struct packed {
      logic [OFF_W-1:0]  offset;
      logic [GAIN_W-1:0] gain;
   } cfg_type;

endpackage

`default_nettype wire

// ===== hdl/wrm_front.sv =====
// Front end: squares samples, accumulates the window and posts closed windows.
`timescale 1ns / 1ps
`default_nettype none

module wrm_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   input  wire logic                        in_action,
   input  wire logic [wrm_pkg::CODE_W-1:0]  in_code,
   output logic                             in_stall,
   output logic                             push,
   output wrm_pkg::job_type                 push_job,
   input  wire logic                        queue_full
);

   logic                        stg_valid_ff, stg_valid_in;
   logic                        stg_end_ff;
   logic [wrm_pkg::SQ_W-1:0]    stg_square_ff;
   logic [wrm_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [wrm_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        overflow_ff, overflow_in;
   logic                        hold;
   logic                        accept;
   logic [wrm_pkg::CODE_USE_W-1:0]   code_use;
   logic [2*wrm_pkg::CODE_USE_W-1:0] square;

   // Hold a window end in the stage until the queue has room
   assign hold     = stg_valid_ff & (stg_end_ff == wrm_pkg::ACTION_END) & queue_full;
   assign in_stall = hold;
   assign accept   = in_valid & ~hold;

   assign code_use = in_code[wrm_pkg::CODE_USE_W-1:0];
   assign square   = code_use * code_use;

   assign stg_valid_in = hold | accept;

   assign push           = stg_valid_ff & (stg_end_ff == wrm_pkg::ACTION_END) & ~queue_full;
   assign push_job.sum      = sum_ff;
   assign push_job.count    = count_ff;
   assign push_job.overflow = overflow_ff;

   always_comb begin
      sum_in      = sum_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (stg_valid_ff && stg_end_ff == wrm_pkg::ACTION_SAMPLE) begin
         if (count_ff >= wrm_pkg::COUNT_W'(wrm_pkg::MAX_SAMPLES)) begin
            overflow_in = 1'b1;
         end else begin
            sum_in   = sum_ff + wrm_pkg::SUM_W'(stg_square_ff);
            count_in = count_ff + wrm_pkg::COUNT_W'(1);
         end
      end else if (push) begin
         sum_in      = '0;
         count_in    = '0;
         overflow_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stg_end_ff    <= in_action;
         stg_square_ff <= wrm_pkg::SQ_W'(square);
      end
   end

endmodule

`default_nettype wire

// ===== hdl/wrm_queue.sv =====
// Short queue of closed windows between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module wrm_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire wrm_pkg::job_type push_job,
   output logic             full,
   input  wire logic        pop,
   output wrm_pkg::job_type pop_job,
   output logic             empty
);

   wrm_pkg::job_type                entry_ff [wrm_pkg::QUEUE_DEPTH];
   logic [wrm_pkg::QPTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [wrm_pkg::QCNT_W-1:0]      fill_ff, fill_in;
   logic                            do_push, do_pop;

   assign full    = (fill_ff == wrm_pkg::QCNT_W'(wrm_pkg::QUEUE_DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign pop_job = entry_ff[rd_ptr_ff];

   function automatic logic [wrm_pkg::QPTR_W-1:0] next_ptr(input logic [wrm_pkg::QPTR_W-1:0] p);
      if (p == wrm_pkg::QPTR_W'(wrm_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + wrm_pkg::QPTR_W'(1);
   endfunction

   always_comb begin
      fill_in = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + wrm_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - wrm_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (do_push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/wrm_back.sv =====
// Back end: mean square division, square root, calibration and result register.
`timescale 1ns / 1ps
`default_nettype none

module wrm_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          job_ready,
   input  wire wrm_pkg::job_type              job,
   output logic                               pop,
   input  wire wrm_pkg::cfg_type              cfg,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [wrm_pkg::RMS_W-1:0]   rsp_rms,
   output logic [wrm_pkg::USED_W-1:0]         rsp_used,
   output logic [wrm_pkg::STATUS_W-1:0]       rsp_status
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_DIV  = 6'b000010,
      ST_ROOT = 6'b000100,
      ST_MAG  = 6'b001000,
      ST_PROD = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   localparam int DW  = wrm_pkg::DIV_W;
   localparam int CW  = wrm_pkg::COUNT_W;
   localparam int RW  = wrm_pkg::RT_W;
   localparam int RIW = wrm_pkg::ROOT_IN_W;

   state_type                      state_ff, state_in;
   logic [wrm_pkg::STEP_W-1:0]     step_ff, step_in;
   logic [CW-1:0]                  divisor_ff, divisor_in;
   logic [DW-1:0]                  dq_ff, dq_in;
   logic [CW-1:0]                  rem_ff, rem_in;
   logic [RIW-1:0]                 rad_ff, rad_in;
   logic [RW-1:0]                  root_ff, root_in;
   logic [RW:0]                    srem_ff, srem_in;
   logic [wrm_pkg::MAG_W-1:0]      mag_ff, mag_in;
   logic                           neg_ff, neg_in;
   logic [wrm_pkg::PROD_W-1:0]     prod_ff, prod_in;
   logic [CW-1:0]                  used_ff, used_in;
   logic                           drop_ff, drop_in;
   logic                           empty_ff, empty_in;

   logic                           out_valid_ff, out_valid_in;
   logic [wrm_pkg::RMS_W-1:0]      out_rms_ff, out_rms_in;
   logic [wrm_pkg::USED_W-1:0]     out_used_ff, out_used_in;
   logic [wrm_pkg::STATUS_W-1:0]   out_status_ff, out_status_in;

   logic [CW:0]                    div_trial;
   logic                           div_ge;
   logic [RW+2:0]                  rt_acc, rt_trial;
   logic                           rt_ge;
   logic [wrm_pkg::MAG_W-1:0]      offq, rootx;
   logic [wrm_pkg::SUMR_W-1:0]     rounded;
   logic [wrm_pkg::SCALED_W-1:0]   scaled, sat;
   logic [wrm_pkg::RMS_W-1:0]      rms_value;
   logic                           out_free;
   logic                           load_out;

   assign out_free = ~out_valid_ff | ~rsp_stall;

   // Restoring division step, one quotient bit per cycle
   assign div_trial = {rem_ff, dq_ff[DW-1]};
   assign div_ge    = (div_trial >= {1'b0, divisor_ff});

   // Square root step, two radicand bits per cycle
   assign rt_acc   = {srem_ff, rad_ff[RIW-1 -: 2]};
   assign rt_trial = {(RW + 1)'(root_ff), 2'b01};
   assign rt_ge    = (rt_acc >= rt_trial);

   assign offq  = wrm_pkg::MAG_W'({cfg.offset, 4'b0000});
   assign rootx = wrm_pkg::MAG_W'(root_ff);

   // Round half away from zero on the magnitude, then saturate
   assign rounded = wrm_pkg::SUMR_W'(prod_ff) + wrm_pkg::ROUND_HALF;
   assign scaled  = rounded[wrm_pkg::SUMR_W-1:wrm_pkg::SCALE_SHIFT];

   always_comb begin
      if (neg_ff) begin
         sat       = (scaled > wrm_pkg::RMS_NEG_MAG) ? wrm_pkg::RMS_NEG_MAG : scaled;
         rms_value = wrm_pkg::RMS_W'(wrm_pkg::SCALED_W'(0) - sat);
      end else begin
         sat       = (scaled > wrm_pkg::RMS_POS_MAX) ? wrm_pkg::RMS_POS_MAX : scaled;
         rms_value = wrm_pkg::RMS_W'(sat);
      end
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      divisor_in = divisor_ff;
      dq_in      = dq_ff;
      rem_in     = rem_ff;
      rad_in     = rad_ff;
      root_in    = root_ff;
      srem_in    = srem_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      prod_in    = prod_ff;
      used_in    = used_ff;
      drop_in    = drop_ff;
      empty_in   = empty_ff;
      pop        = 1'b0;
      load_out   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (job_ready) begin
               pop        = 1'b1;
               divisor_in = job.count;
               dq_in      = {job.sum, wrm_pkg::FRAC_W'(0)};
               rem_in     = '0;
               used_in    = job.count;
               drop_in    = job.overflow;
               empty_in   = (job.count == '0);
               step_in    = '0;
               state_in   = (job.count == '0) ? ST_DONE : ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = div_ge ? CW'(div_trial - {1'b0, divisor_ff}) : div_trial[CW-1:0];
            dq_in   = {dq_ff[DW-2:0], div_ge};
            step_in = step_ff + wrm_pkg::STEP_W'(1);
            if (step_ff == wrm_pkg::STEP_W'(DW - 1)) begin
               rad_in   = RIW'(dq_in);
               root_in  = '0;
               srem_in  = '0;
               step_in  = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            srem_in = rt_ge ? (RW + 1)'(rt_acc - rt_trial) : (RW + 1)'(rt_acc);
            root_in = {root_ff[RW-2:0], rt_ge};
            rad_in  = rad_ff << 2;
            step_in = step_ff + wrm_pkg::STEP_W'(1);
            if (step_ff == wrm_pkg::STEP_W'(RW - 1)) begin
               state_in = ST_MAG;
            end
         end
         ST_MAG: begin
            neg_in   = (rootx < offq);
            mag_in   = (rootx < offq) ? (offq - rootx) : (rootx - offq);
            state_in = ST_PROD;
         end
         ST_PROD: begin
            prod_in  = wrm_pkg::PROD_W'(mag_ff) * wrm_pkg::PROD_W'(cfg.gain);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_rms_in    = out_rms_ff;
      out_used_in   = out_used_ff;
      out_status_in = out_status_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
         if (empty_ff) begin
            out_rms_in    = '0;
            out_used_in   = '0;
            out_status_in = wrm_pkg::STATUS_EMPTY;
         end else begin
            out_rms_in    = rms_value;
            out_used_in   = wrm_pkg::USED_W'(used_ff);
            out_status_in = drop_ff ? wrm_pkg::STATUS_DROP : wrm_pkg::STATUS_OK;
         end
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff    <= divisor_in;
      dq_ff         <= dq_in;
      rem_ff        <= rem_in;
      rad_ff        <= rad_in;
      root_ff       <= root_in;
      srem_ff       <= srem_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      prod_ff       <= prod_in;
      used_ff       <= used_in;
      drop_ff       <= drop_in;
      empty_ff      <= empty_in;
      out_rms_ff    <= out_rms_in;
      out_used_ff   <= out_used_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_rms    = out_rms_ff;
   assign rsp_used   = out_used_ff;
   assign rsp_status = out_status_ff;

endmodule

`default_nettype wire

// ===== hdl/windowed_rms_meter_unit.sv =====
// Top level of the windowed true-RMS meter.
//
// Request channel (req_*): one word per cycle while req_stall is low. action 0
// carries an ADC code that is squared and added to the open window; action 1
// closes the window. Samples past MAX_SAMPLES in one window are dropped and flagged.
// Response channel (rsp_*): one word per closed window: calibrated RMS in mV,
// the sample count and a status code (ok, empty window, samples dropped).
// Config port (csr_*): index 0 is the offset code, index 1 the Q8 gain; write
// only while the block is idle. Other indexes are ignored.
//
// Throughput: samples are taken every cycle while req_stall is low. A window end is
// posted to a two-deep queue; the back end takes one window at a time through idle,
// one divider step per quotient bit, one root step per root bit, then magnitude,
// product and done, and two closed windows may wait in the queue while it works.
// req_stall rises only when a window end meets a full queue.
// When rsp_stall is high the response holds; the back end finishes the next
// window and waits, the front keeps accumulating.
// Reset clears the window, queue and response, and loads the default
// calibration (offset 503 codes, gain 51441).
`timescale 1ns / 1ps
`default_nettype none

module windowed_rms_meter_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_action,
   input  wire logic [wrm_pkg::CODE_W-1:0]        req_sample_code,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [wrm_pkg::RMS_W-1:0]       rsp_rms_millivolts,
   output logic [wrm_pkg::USED_W-1:0]             rsp_samples_used,
   output logic [wrm_pkg::STATUS_W-1:0]           rsp_status,
   input  wire logic                              csr_write,
   input  wire logic [wrm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [wrm_pkg::CSR_W-1:0]         csr_data
);

   wrm_pkg::cfg_type  cfg_ff;
   wrm_pkg::job_type  push_job;
   wrm_pkg::job_type  pop_job;
   logic              push;
   logic              pop;
   logic              queue_full;
   logic              queue_empty;

   // Calibration registers; unused indexes drop the write
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset <= wrm_pkg::OFFSET_RESET;
         cfg_ff.gain   <= wrm_pkg::GAIN_RESET;
      end else if (csr_write) begin
         case (csr_index)
            wrm_pkg::CSR_OFFSET: cfg_ff.offset <= csr_data[wrm_pkg::OFF_W-1:0];
            wrm_pkg::CSR_GAIN:   cfg_ff.gain   <= csr_data[wrm_pkg::GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Accumulate the window
   wrm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_action  (req_action),
      .in_code    (req_sample_code),
      .in_stall   (req_stall),
      .push       (push),
      .push_job   (push_job),
      .queue_full (queue_full)
   );

   // Buffer closed windows
   wrm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (queue_empty)
   );

   // Divide, root, calibrate
   wrm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_ready  (~queue_empty),
      .job        (pop_job),
      .pop        (pop),
      .cfg        (cfg_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_rms    (rsp_rms_millivolts),
      .rsp_used   (rsp_samples_used),
      .rsp_status (rsp_status)
   );

endmodule

`default_nettype wire

// ===== hdl/wrm_checker.sv =====
// Port-level checks of the windowed RMS meter, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module wrm_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_stall,
   input wire logic signed [wrm_pkg::RMS_W-1:0]   rsp_rms_millivolts,
   input wire logic [wrm_pkg::USED_W-1:0]         rsp_samples_used,
   input wire logic [wrm_pkg::STATUS_W-1:0]       rsp_status
);

   // Hold a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_rms_millivolts)
         && $stable(rsp_samples_used) && $stable(rsp_status))
      else $error("response word changed while stalled");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == wrm_pkg::STATUS_EMPTY
         |-> rsp_rms_millivolts == '0 && rsp_samples_used == '0)
      else $error("empty window reported nonzero fields");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == wrm_pkg::STATUS_DROP
         |-> rsp_samples_used == wrm_pkg::USED_W'(wrm_pkg::MAX_SAMPLES))
      else $error("dropped-sample window not at full count");

   a_ok_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == wrm_pkg::STATUS_OK |-> rsp_samples_used != '0)
      else $error("ok status with no samples");

endmodule

bind windowed_rms_meter_unit wrm_checker u_wrm_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_rms_millivolts (rsp_rms_millivolts),
   .rsp_samples_used   (rsp_samples_used),
   .rsp_status         (rsp_status)
);

`default_nettype wire

// ===== verif/wrm_reading_checker.sv =====
// Checker for the windowed RMS meter: watches both channels, predicts readings, compares them.
`timescale 1ns / 1ps

module wrm_reading_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_stall,
   input  wire logic                                req_action,
   input  wire logic [wrm_pkg::CODE_W-1:0]          req_sample_code,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   input  wire logic signed [wrm_pkg::RMS_W-1:0]    rsp_rms_millivolts,
   input  wire logic [wrm_pkg::USED_W-1:0]          rsp_samples_used,
   input  wire logic [wrm_pkg::STATUS_W-1:0]        rsp_status,
   input  wire logic                                csr_write,
   input  wire logic [wrm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [wrm_pkg::CSR_W-1:0]           csr_data,
   output int                                       fail_count,
   output int                                       pending
);

   localparam int PRINT_CAP = 200;

   typedef struct packed {
      logic signed [wrm_pkg::RMS_W-1:0] rms_mv;
      logic [wrm_pkg::USED_W-1:0]       used;
      logic [wrm_pkg::STATUS_W-1:0]     status;
   } reading_type;

   // Shadow of the open window and the calibration
   logic [wrm_pkg::SUM_W-1:0]      win_sum;
   logic [wrm_pkg::COUNT_W-1:0]    win_count;
   logic                           win_dropped;
   logic [wrm_pkg::OFF_W-1:0]      cal_offset;
   logic [wrm_pkg::GAIN_W-1:0]     cal_gain;
   logic [wrm_pkg::CODE_USE_W-1:0] sample_use;

   reading_type due_readings[$];
   int          readings_seen;

   initial begin
      fail_count    = 0;
      pending       = 0;
      readings_seen = 0;
   end

   task automatic flag_mismatch(input string msg);
      if (fail_count < PRINT_CAP)
         $display("%0t MISMATCH: %s", $realtime, msg);
      fail_count++;
   endtask

   function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      // mean square stays below 2^42, so the root fits in 21 bits
      for (int i = 22; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= x)
            root = trial;
      end
      return root;
   endfunction

   function automatic reading_type finish_window();
      reading_type r;
      logic [63:0] mean_sq;
      logic [63:0] root;
      logic [63:0] off_q4;
      logic [63:0] mag;
      logic [63:0] scaled;
      logic        neg;
      if (win_count == '0) begin
         r.rms_mv = '0;
         r.used   = '0;
         r.status = wrm_pkg::STATUS_EMPTY;
         return r;
      end
      mean_sq = (64'(win_sum) << 8) / 64'(win_count);
      root    = floor_sqrt(mean_sq);
      off_q4  = 64'(cal_offset) << 4;
      neg     = root < off_q4;
      mag     = neg ? off_q4 - root : root - off_q4;
      // Q4 times Q8 gives Q12; round half away from zero on the magnitude
      scaled  = (mag * 64'(cal_gain) + 64'd2048) >> 12;
      if (neg) begin
         if (scaled > 64'(wrm_pkg::RMS_NEG_MAG))
            scaled = 64'(wrm_pkg::RMS_NEG_MAG);
         r.rms_mv = wrm_pkg::RMS_W'(64'd0 - scaled);
      end else begin
         if (scaled > 64'(wrm_pkg::RMS_POS_MAX))
            scaled = 64'(wrm_pkg::RMS_POS_MAX);
         r.rms_mv = wrm_pkg::RMS_W'(scaled);
      end
      r.used   = wrm_pkg::USED_W'(win_count);
      r.status = win_dropped ? wrm_pkg::STATUS_DROP : wrm_pkg::STATUS_OK;
      return r;
   endfunction

   task automatic check_reading();
      reading_type want;
      readings_seen++;
      if (due_readings.size() == 0) begin
         flag_mismatch($sformatf("reading %0d unexpected: rms=%0d used=%0d status=%0d",
                                 readings_seen, rsp_rms_millivolts, rsp_samples_used,
                                 rsp_status));
      end else begin
         want = due_readings.pop_front();
         if (rsp_rms_millivolts !== want.rms_mv)
            flag_mismatch($sformatf("reading %0d rms_millivolts got %0d want %0d",
                                    readings_seen, rsp_rms_millivolts, want.rms_mv));
         if (rsp_samples_used !== want.used)
            flag_mismatch($sformatf("reading %0d samples_used got %0d want %0d",
                                    readings_seen, rsp_samples_used, want.used));
         if (rsp_status !== want.status)
            flag_mismatch($sformatf("reading %0d status got %0d want %0d",
                                    readings_seen, rsp_status, want.status));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         win_sum     = '0;
         win_count   = '0;
         win_dropped = 1'b0;
         cal_offset  = wrm_pkg::OFFSET_RESET;
         cal_gain    = wrm_pkg::GAIN_RESET;
         due_readings.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == wrm_pkg::CSR_OFFSET)
               cal_offset = csr_data[wrm_pkg::OFF_W-1:0];
            else if (csr_index == wrm_pkg::CSR_GAIN)
               cal_gain = csr_data[wrm_pkg::GAIN_W-1:0];
         end
         if (rsp_valid && !rsp_stall)
            check_reading();
         if (req_valid && !req_stall) begin
            if (req_action == wrm_pkg::ACTION_SAMPLE) begin
               sample_use = req_sample_code[wrm_pkg::CODE_USE_W-1:0];
               if (win_count >= wrm_pkg::COUNT_W'(wrm_pkg::MAX_SAMPLES)) begin
                  win_dropped = 1'b1;
               end else begin
                  win_sum   = win_sum + wrm_pkg::SUM_W'(sample_use)
                                        * wrm_pkg::SUM_W'(sample_use);
                  win_count = win_count + wrm_pkg::COUNT_W'(1);
               end
            end else begin
               due_readings.push_back(finish_window());
               win_sum     = '0;
               win_count   = '0;
               win_dropped = 1'b0;
            end
         end
      end
      pending = due_readings.size();
   end

endmodule

// ===== verif/tb_windowed_rms_meter_unit.sv =====
// Testbench top for the windowed RMS meter: drives words and registers, gives the verdict.
`timescale 1ns / 1ps

module tb_windowed_rms_meter_unit;

   // Register indexes that the block must ignore
   localparam logic [wrm_pkg::CSR_IDX_W-1:0] CSR_IDX_SPARE_LO = 2'd2;
   localparam logic [wrm_pkg::CSR_IDX_W-1:0] CSR_IDX_SPARE_HI = 2'd3;

   // Margin after the last reading before a register write
   localparam int SETTLE_CYCLES = 80;
   localparam int TAIL_CYCLES   = 100;
   localparam int SEG_WORDS     = 104;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic                                req_action;
   logic [wrm_pkg::CODE_W-1:0]          req_sample_code;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic signed [wrm_pkg::RMS_W-1:0]    rsp_rms_millivolts;
   logic [wrm_pkg::USED_W-1:0]          rsp_samples_used;
   logic [wrm_pkg::STATUS_W-1:0]        rsp_status;
   logic                                csr_write;
   logic [wrm_pkg::CSR_IDX_W-1:0]       csr_index;
   logic [wrm_pkg::CSR_W-1:0]           csr_data;

   int fail_count;
   int pending;
   int words_sent;
   int send_idle_pct;
   int recv_stall_pct;

   windowed_rms_meter_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_sample_code    (req_sample_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_rms_millivolts (rsp_rms_millivolts),
      .rsp_samples_used   (rsp_samples_used),
      .rsp_status         (rsp_status),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   wrm_reading_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_sample_code    (req_sample_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_rms_millivolts (rsp_rms_millivolts),
      .rsp_samples_used   (rsp_samples_used),
      .rsp_status         (rsp_status),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop: far beyond the slowest legal run
   initial begin
      #(10_000_000);
      $display("tb_windowed_rms_meter_unit failed");
      $finish;
   end

   // Receiver side: stall at the rate of the current phase, decided at each falling edge
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall = ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // Code mix: favor the two extremes now and then, otherwise uniform over all bits
   function automatic logic [wrm_pkg::CODE_W-1:0] pick_code();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return wrm_pkg::CODE_W'($urandom);
      endcase
   endfunction

   // Hand one word to the block. Call and return right after a falling edge.
   // Idle gaps come first, so they land between any two words of a window.
   task automatic send_word(input logic act, input logic [wrm_pkg::CODE_W-1:0] code);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid       = 1'b0;
         req_action      = 1'($urandom);
         req_sample_code = wrm_pkg::CODE_W'($urandom);
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_action      = act;
      req_sample_code = code;
      // hold the word until an edge takes it
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   // Send n samples and close the window; fill < 0 picks random codes
   task automatic send_window(input int n, input int fill);
      for (int k = 0; k < n; k++)
         send_word(wrm_pkg::ACTION_SAMPLE,
                   (fill < 0) ? pick_code() : wrm_pkg::CODE_W'(fill));
      send_word(wrm_pkg::ACTION_END, wrm_pkg::CODE_W'($urandom));
   endtask

   // Drop valid and wait until every predicted reading has come back, then settle
   task automatic drain_block();
      req_valid = 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [wrm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [wrm_pkg::CSR_W-1:0] data);
      drain_block();
      csr_write = 1'b1;
      csr_index = idx;
      csr_data  = data;
      @(negedge clock);
      csr_write = 1'b0;
      csr_data  = wrm_pkg::CSR_W'($urandom);
   endtask

   initial begin
      int                          seg;
      int                          seg_end;
      int                          pick;
      int                          len;
      logic [wrm_pkg::CSR_W-1:0]   off_data;
      logic [wrm_pkg::CSR_W-1:0]   gain_data;

      // Known values on every input from time zero
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_action      = wrm_pkg::ACTION_SAMPLE;
      req_sample_code = '0;
      csr_write       = 1'b0;
      csr_index       = wrm_pkg::CSR_OFFSET;
      csr_data        = '0;
      words_sent      = 0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;

      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Directed part, default calibration first.
      // Close an empty window straight out of reset.
      send_word(wrm_pkg::ACTION_END, '0);
      send_window(1, 0);
      send_window(3, 4095);
      send_window(2, -1);

      // Zero offset, full gain: full-scale codes saturate high
      write_reg(wrm_pkg::CSR_OFFSET, '0);
      write_reg(wrm_pkg::CSR_GAIN, '1);
      send_window(2, 4095);
      send_window(1, 0);

      // Full offset, full gain: all-zero window saturates low
      write_reg(wrm_pkg::CSR_OFFSET, wrm_pkg::CSR_W'({wrm_pkg::OFF_W{1'b1}}));
      send_window(1, 0);

      // Zero gain flattens everything
      write_reg(wrm_pkg::CSR_GAIN, '0);
      send_window(4, -1);

      // Writes to unused indexes must leave the calibration alone
      write_reg(wrm_pkg::CSR_GAIN, wrm_pkg::CSR_W'(wrm_pkg::GAIN_RESET));
      write_reg(wrm_pkg::CSR_OFFSET, wrm_pkg::CSR_W'(wrm_pkg::OFFSET_RESET));
      write_reg(CSR_IDX_SPARE_LO, '1);
      write_reg(CSR_IDX_SPARE_HI, wrm_pkg::CSR_W'($urandom));
      send_window(2, -1);

      // Exactly full window, then one that drops two samples
      send_window(wrm_pkg::MAX_SAMPLES, -1);
      send_window(wrm_pkg::MAX_SAMPLES + 2, -1);

      // Back-to-back window ends: fill the job queue and force req_stall
      repeat (4) send_word(wrm_pkg::ACTION_END, wrm_pkg::CODE_W'($urandom));

      // Random part: four idling phases, each under two calibration settings
      for (seg = 0; seg < 8; seg++) begin
         case (seg % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
         endcase

         case ($urandom_range(0, 3))
            0: begin
               off_data  = wrm_pkg::CSR_W'(wrm_pkg::OFFSET_RESET);
               gain_data = wrm_pkg::CSR_W'(wrm_pkg::GAIN_RESET);
            end
            1: begin
               off_data  = $urandom_range(0, 1) ?
                           wrm_pkg::CSR_W'({wrm_pkg::OFF_W{1'b1}}) : '0;
               gain_data = $urandom_range(0, 1) ? '1 : '0;
            end
            default: begin
               // upper data bits on the offset write must be dropped by the block
               off_data  = wrm_pkg::CSR_W'($urandom);
               gain_data = wrm_pkg::CSR_W'($urandom);
            end
         endcase
         write_reg(wrm_pkg::CSR_OFFSET, off_data);
         write_reg(wrm_pkg::CSR_GAIN, gain_data);
         if ($urandom_range(0, 2) == 0)
            write_reg(seg[0] ? CSR_IDX_SPARE_HI : CSR_IDX_SPARE_LO,
                      wrm_pkg::CSR_W'($urandom));

         seg_end = words_sent + SEG_WORDS;
         while (words_sent < seg_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
               // stray window end: empty window or a close right after another
               send_word(wrm_pkg::ACTION_END, wrm_pkg::CODE_W'($urandom));
            end else if (pick < 12) begin
               // broken sequence: samples with no close, merged into the next window
               repeat ($urandom_range(1, 6)) send_word(wrm_pkg::ACTION_SAMPLE, pick_code());
            end else begin
               if ($urandom_range(0, 79) == 0)
                  len = $urandom_range(wrm_pkg::MAX_SAMPLES - 8, wrm_pkg::MAX_SAMPLES + 12);
               else
                  len = $urandom_range(1, 24);
               send_window(len, -1);
            end
         end
         // close whatever is open before the calibration moves
         send_word(wrm_pkg::ACTION_END, wrm_pkg::CODE_W'($urandom));
      end

      // Wait out every reading, then watch for strays
      drain_block();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (TAIL_CYCLES) @(negedge clock);

      if (fail_count == 0 && pending == 0)
         $display("tb_windowed_rms_meter_unit passed");
      else
         $display("tb_windowed_rms_meter_unit failed");
      $finish;
   end

endmodule
